@@ design/dsu_pkg.sv @@
// Shared types and constants for the union-find engine.
package dsu_pkg;

  localparam int LABEL_W = 12;

  localparam logic MODE_FIND  = 1'b0;
  localparam logic MODE_UNION = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [LABEL_W-1:0] node_a;
    logic [LABEL_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               op_kind;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_WALK,
    ST_FIND_FIX,
    ST_JOIN,
    ST_DONE
  } eng_state_t;

endpackage

@@ design/dsu_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dsu_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/dsu_engine.sv @@
// Sequencer for table clear, find with path compression and Rem union with splicing.
module dsu_engine #(
  parameter int NODE_COUNT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dsu_pkg::in_t                  in_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output dsu_pkg::out_t                 res_data,
  output logic                          wr_en,
  output logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  output logic [$clog2(NODE_COUNT)-1:0] wr_data,
  output logic                          rd_en,
  output logic [$clog2(NODE_COUNT)-1:0] rd_addr_a,
  output logic [$clog2(NODE_COUNT)-1:0] rd_addr_b,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_data_a,
  input  logic [$clog2(NODE_COUNT)-1:0] rd_data_b
);

  import dsu_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);

  eng_state_t         st_r, st_nxt;
  logic [IDX_W-1:0]   n0_r, n0_nxt;
  logic [IDX_W-1:0]   n1_r, n1_nxt;
  logic [IDX_W-1:0]   start_r, start_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               mode_r, mode_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic               in_ok;
  logic [IDX_W-1:0]   in_a;
  logic [IDX_W-1:0]   in_b;

  assign in_a  = IDX_W'(in_data.node_a);
  assign in_b  = IDX_W'(in_data.node_b);
  assign in_ok = (32'(in_data.node_a) < NODE_COUNT) &&
                 ((in_data.mode == MODE_FIND) || (32'(in_data.node_b) < NODE_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n0_r    <= n0_nxt;
    n1_r    <= n1_nxt;
    start_r <= start_nxt;
    mode_r  <= mode_nxt;
    label_r <= label_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    n0_nxt    = n0_r;
    n1_nxt    = n1_r;
    start_nxt = start_r;
    mode_nxt  = mode_r;
    label_nxt = label_r;
    clr_nxt   = clr_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = n0_r;
    wr_data   = n1_r;
    rd_en     = 1'b0;
    rd_addr_a = n0_r;
    rd_addr_b = n1_r;
    unique case (st_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt  = in_data.mode;
          start_nxt = in_a;
          n0_nxt    = in_a;
          n1_nxt    = in_b;
          label_nxt = in_data.node_a;
          if (!in_ok) begin
            st_nxt = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = in_a;
            rd_addr_b = in_b;
            st_nxt    = (in_data.mode == MODE_FIND) ? ST_FIND_WALK : ST_JOIN;
          end
        end
      end
      ST_FIND_WALK: begin
        if (rd_data_a == n0_r) begin
          n1_nxt = start_r;
          if (start_r == n0_r) begin
            label_nxt = LABEL_W'(n0_r);
            st_nxt    = ST_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = start_r;
            st_nxt    = ST_FIND_FIX;
          end
        end else begin
          n0_nxt    = rd_data_a;
          rd_en     = 1'b1;
          rd_addr_a = rd_data_a;
        end
      end
      ST_FIND_FIX: begin
        wr_en   = 1'b1;
        wr_addr = n1_r;
        wr_data = n0_r;
        n1_nxt  = rd_data_a;
        if (rd_data_a == n0_r) begin
          label_nxt = LABEL_W'(n0_r);
          st_nxt    = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr_a = rd_data_a;
          rd_addr_b = rd_data_a;
        end
      end
      ST_JOIN: begin
        if (rd_data_a == rd_data_b) begin
          label_nxt = LABEL_W'(rd_data_a);
          st_nxt    = ST_DONE;
        end else if (rd_data_a < rd_data_b) begin
          wr_en   = 1'b1;
          wr_addr = n0_r;
          wr_data = rd_data_b;
          if (n0_r == rd_data_a) begin
            label_nxt = LABEL_W'(rd_data_b);
            st_nxt    = ST_DONE;
          end else begin
            n0_nxt    = rd_data_a;
            rd_en     = 1'b1;
            rd_addr_a = rd_data_a;
            rd_addr_b = n1_r;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = n1_r;
          wr_data = rd_data_a;
          if (n1_r == rd_data_b) begin
            label_nxt = LABEL_W'(rd_data_a);
            st_nxt    = ST_DONE;
          end else begin
            n1_nxt    = rd_data_b;
            rd_en     = 1'b1;
            rd_addr_a = n0_r;
            rd_addr_b = rd_data_b;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_data = '{label: label_r, op_kind: mode_r};

endmodule

@@ design/disjoint_set_union_find_core.sv @@
// Top level of the union-find engine: mirrored parent tables, sequencer, output register.
//
//  channel | signals                       | beat carries
//  --------+-------------------------------+------------------------------
//  in      | in_valid in_ready in_data     | mode, node_a, node_b
//  out     | out_valid out_ready out_data  | label, op_kind
//
// A find does one table read per step up the path of links above node_a and one
// read-modify-write per step of compression; a union does one read-modify-write per
// splice step. The single table read port per copy sets this pace.
// After reset all NODE_COUNT table entries are rewritten to identity; in_ready stays low until then.
// One finished beat waits in the output register while the next item is taken.
module disjoint_set_union_find_core #(
  parameter int NODE_COUNT = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dsu_pkg::out_t out_data
);

  import dsu_pkg::*;

  localparam int IDX_W = $clog2(NODE_COUNT);

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  logic [IDX_W-1:0] rd_data_a;
  logic [IDX_W-1:0] rd_data_b;
  logic             res_valid;
  logic             res_ready;
  out_t             res_data;
  logic             out_valid_r;
  out_t             out_data_r;

  dsu_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NODE_COUNT)
  ) u_ram_a (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr_a),
    .rd_data(rd_data_a)
  );

  dsu_ram #(
    .WIDTH(IDX_W),
    .DEPTH(NODE_COUNT)
  ) u_ram_b (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr_b),
    .rd_data(rd_data_b)
  );

  dsu_engine #(
    .NODE_COUNT(NODE_COUNT)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_no_rw_collision_a: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr_a))
    else $error("table read and write hit the same entry on copy a");

  a_no_rw_collision_b: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr_b))
    else $error("table read and write hit the same entry on copy b");

  a_parent_not_below: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_data >= wr_addr))
    else $error("parent written below its node");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while previous one still in work");
`endif

endmodule
